// File: hdl/gb5_pkg.sv
// ----------------------------------------------------------------------------
// gb5_pkg: shared types, constants and helpers of the 5x5 Gaussian blur.
// Holds the kernel weights, the divide-by-273 reciprocal and the beat structs.
// ----------------------------------------------------------------------------
package gb5_pkg;

  // Frame geometry and sample width.
  localparam int MAX_WIDTH  = 4096;
  localparam int PIXEL_BITS = 16;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WCFG_W     = 13;
  localparam int HCFG_W     = 16;
  localparam int ROW_W      = HCFG_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [WCFG_W-1:0]    RESET_WIDTH      = 13'd1024;
  localparam logic [HCFG_W-1:0]    RESET_HEIGHT     = 16'd1024;

  // Line store: four earlier rows side by side in one word per column.
  localparam int LINES  = 4;
  localparam int WORD_W = LINES * PIXEL_BITS;

  // Arithmetic widths. The weights add up to 273, which is below 2**9.
  localparam int ROW_SUM_W = PIXEL_BITS + 7;
  localparam int TOTAL_W   = PIXEL_BITS + 9;
  localparam int DIV_SHIFT = TOTAL_W + 9;
  localparam int RECIP_W   = DIV_SHIFT - 8;
  localparam int PROD_W    = TOTAL_W + RECIP_W;
  localparam logic [TOTAL_W-1:0] ROUND_BIAS = TOTAL_W'(136);
  localparam logic [RECIP_W-1:0] DIV_RECIP  =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd272) / 64'd273);

  // Kernel weights, row by row.
  localparam logic [5:0] KERN [5][5] = '{
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
  };

  // Output queue.
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = OQ_PTR_W + 1;

  typedef logic [PIXEL_BITS-1:0] sample_t;
  typedef sample_t [4:0]         vec_t;
  typedef vec_t [4:0]            window_t;
  typedef sample_t [LINES-1:0]   word_t;
  typedef logic [1:0]            lim_t;

  // Everything the datapath needs to know about one accepted beat.
  typedef struct packed {
    logic             we;
    logic             emit;
    logic             last;
    logic [COL_W-1:0] col;
    logic [1:0]       slot;
    lim_t             up_lim;
    lim_t             dn_lim;
    lim_t             left_lim;
    lim_t             right_lim;
    sample_t          pixel;
  } item_t;

  // Marks a result traveling down the arithmetic pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  // Edge clamp on five samples centered on index 2: lo and hi give how many
  // neighbors exist on each side, missing ones repeat the outermost one.
  function automatic vec_t pick5(vec_t v, lim_t lo, lim_t hi);
    vec_t r;
    r[2] = v[2];
    r[1] = (lo == 2'd0) ? v[2] : v[1];
    r[0] = (lo == 2'd0) ? v[2] : ((lo == 2'd1) ? v[1] : v[0]);
    r[3] = (hi == 2'd0) ? v[2] : v[3];
    r[4] = (hi == 2'd0) ? v[2] : ((hi == 2'd1) ? v[3] : v[4]);
    return r;
  endfunction

  // The same clamp applied to whole columns of the window.
  function automatic window_t pick5_win(window_t v, lim_t lo, lim_t hi);
    window_t r;
    r[2] = v[2];
    r[1] = (lo == 2'd0) ? v[2] : v[1];
    r[0] = (lo == 2'd0) ? v[2] : ((lo == 2'd1) ? v[1] : v[0]);
    r[3] = (hi == 2'd0) ? v[2] : v[3];
    r[4] = (hi == 2'd0) ? v[2] : ((hi == 2'd1) ? v[3] : v[4]);
    return r;
  endfunction

endpackage

// File: hdl/gb5_ram.sv
// ----------------------------------------------------------------------------
// gb5_ram: simple dual-port RAM with a registered read.
// One write and one read per cycle; a read of the address being written
// returns the old contents.
// ----------------------------------------------------------------------------
module gb5_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read-first registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/gb5_ctrl.sv
// ----------------------------------------------------------------------------
// gb5_ctrl: configuration registers and frame position counters.
// Decides per input beat whether it is stored, ignored or produces a result,
// and works out the edge clamp limits for the datapath.
// ----------------------------------------------------------------------------
module gb5_ctrl import gb5_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic                  kind,
  input  sample_t               pixel,
  output logic                  go,
  output item_t                 item
);

  logic [WCFG_W-1:0] image_width;
  logic [HCFG_W-1:0] image_height;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [HCFG_W-1:0] out_row;
  logic [COL_W-1:0]  out_col;

  logic [WCFG_W-1:0] w_eff;
  logic [HCFG_W-1:0] h_eff;
  logic [ROW_W-1:0]  h_ext;
  logic [WCFG_W-1:0] right_room;
  logic              in_frame;
  logic              pre_lag;
  logic              in_col_wrap;
  logic              out_col_wrap;

  // Effective geometry: zero acts as one, the width saturates at the maximum.
  always_comb begin
    if (image_width == '0) begin
      w_eff = WCFG_W'(1);
    end else if (image_width > WCFG_W'(MAX_WIDTH)) begin
      w_eff = WCFG_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height == '0) ? HCFG_W'(1) : image_height;
  end

  assign h_ext = ROW_W'(h_eff);

  // Beat classification. A result is due once the input is 2*width+2 beats
  // ahead of the output, which the row and column counters tell directly.
  assign in_frame = in_row < h_ext;
  assign pre_lag  = (in_row < ROW_W'(2))
                 || (in_row == ROW_W'(2) && in_col < COL_W'(2))
                 || (in_row == ROW_W'(3) && w_eff == WCFG_W'(1));
  assign go       = accept && !(in_frame && kind);

  assign in_col_wrap  = (WCFG_W'(in_col) + WCFG_W'(1)) >= w_eff;
  assign out_col_wrap = (WCFG_W'(out_col) + WCFG_W'(1)) >= w_eff;
  assign right_room   = w_eff - WCFG_W'(1) - WCFG_W'(out_col);

  // Beat descriptor with the neighbor counts used by the edge clamp.
  always_comb begin
    item.we    = in_frame;
    item.emit  = !pre_lag;
    item.last  = !pre_lag && out_row == (h_eff - HCFG_W'(1))
              && WCFG_W'(out_col) == (w_eff - WCFG_W'(1));
    item.col   = in_col;
    item.slot  = in_row[1:0];
    item.pixel = pixel;

    // The column arriving now is centered two rows above the input row.
    if (in_row <= ROW_W'(2)) begin
      item.up_lim = 2'd0;
    end else if (in_row == ROW_W'(3)) begin
      item.up_lim = 2'd1;
    end else begin
      item.up_lim = 2'd2;
    end
    if (in_row >= h_ext + ROW_W'(1)) begin
      item.dn_lim = 2'd0;
    end else if (in_row == h_ext) begin
      item.dn_lim = 2'd1;
    end else begin
      item.dn_lim = 2'd2;
    end

    item.left_lim  = (out_col >= COL_W'(2)) ? 2'd2 : out_col[1:0];
    item.right_lim = (right_room >= WCFG_W'(2)) ? 2'd2 : right_room[1:0];
  end

  // Registers and counters. A register write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
      in_row       <= '0;
      in_col       <= '0;
      out_row      <= '0;
      out_col      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WCFG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HCFG_W-1:0];
      endcase
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (go) begin
      if (item.last) begin
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
      end else begin
        if (in_col_wrap) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
        if (item.emit) begin
          if (out_col_wrap) begin
            out_col <= '0;
            out_row <= out_row + HCFG_W'(1);
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end
      end
    end
  end

endmodule

// File: hdl/gb5_column.sv
// ----------------------------------------------------------------------------
// gb5_column: line store and 5x5 window assembly.
// Each beat reads one column word of four earlier rows, merges in the new
// sample, writes it back, and pushes a vertically clamped column into the
// window shift register.
// ----------------------------------------------------------------------------
module gb5_column import gb5_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    go,
  input  item_t   item,
  output tag_t    win_tag,
  output window_t window
);

  logic [WORD_W-1:0] rdata;
  word_t             rd_word;
  word_t             word;
  word_t             merged;
  word_t             fwd_word;
  logic              fwd_hit;
  logic              store_we;

  logic              s1_valid;
  item_t             s1_item;
  vec_t              raw;
  vec_t              vec;

  window_t           hs;
  tag_t              s2_tag;
  lim_t              s2_left;
  lim_t              s2_right;
  window_t           win_c;

  assign store_we = s1_valid && s1_item.we;
  assign rd_word  = word_t'(rdata);

  gb5_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (s1_item.col),
    .wdata (WORD_W'(merged)),
    .raddr (item.col),
    .rdata (rdata)
  );

  // Read data, bypassed by the word written back in the same cycle the read
  // was issued (consecutive beats on one column, as with a width of one).
  always_comb begin
    word = fwd_hit ? fwd_word : rd_word;
    for (int i = 0; i < LINES; i++) begin
      merged[i] = (2'(i) == s1_item.slot) ? s1_item.pixel : word[i];
    end
    // Rows input-4 .. input-1 sit in the current slot and the three after it.
    for (int k = 0; k < LINES; k++) begin
      raw[k] = word[2'(s1_item.slot + 2'(k))];
    end
    raw[4] = s1_item.pixel;
    vec    = pick5(raw, s1_item.up_lim, s1_item.dn_lim);
  end

  // Horizontal clamp on the five newest columns.
  assign win_c = pick5_win(hs, s2_left, s2_right);

  // Control state of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
      s2_tag   <= '0;
      win_tag  <= '0;
    end else begin
      s1_valid     <= go;
      fwd_hit      <= go && store_we && (s1_item.col == item.col);
      s2_tag.valid <= s1_valid && s1_item.emit;
      s2_tag.last  <= s1_item.last;
      win_tag      <= s2_tag;
    end
  end

  // Payload: beat descriptor, bypass word, column shift register, window.
  always_ff @(posedge clk) begin
    s1_item  <= item;
    fwd_word <= merged;
    s2_left  <= s1_item.left_lim;
    s2_right <= s1_item.right_lim;
    window   <= win_c;
    if (s1_valid) begin
      for (int j = 0; j < 4; j++) begin
        hs[j] <= hs[j+1];
      end
      hs[4] <= vec;
    end
  end

endmodule

// File: hdl/gb5_filter.sv
// ----------------------------------------------------------------------------
// gb5_filter: weighted sum of the 5x5 window and rounded division by 273.
// Row sums, total with rounding bias, then a reciprocal multiply.
// ----------------------------------------------------------------------------
module gb5_filter import gb5_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  tag_t    in_tag,
  input  window_t window,
  output tag_t    out_tag,
  output sample_t blurred
);

  logic [ROW_SUM_W-1:0] rs_c [5];
  logic [ROW_SUM_W-1:0] rs_q [5];
  logic [TOTAL_W-1:0]   tot_c;
  logic [TOTAL_W-1:0]   tot_q;
  logic [PROD_W-1:0]    prod_q;
  tag_t                 rs_tag;
  tag_t                 tot_tag;

  // One weighted sum per kernel row.
  always_comb begin
    for (int r = 0; r < 5; r++) begin
      rs_c[r] = '0;
      for (int c = 0; c < 5; c++) begin
        rs_c[r] = rs_c[r]
                + ROW_SUM_W'(window[c][r]) * ROW_SUM_W'(KERN[r][c]);
      end
    end
  end

  // Total plus half the divisor, so the floor below rounds to nearest.
  always_comb begin
    tot_c = ROUND_BIAS;
    for (int r = 0; r < 5; r++) begin
      tot_c = tot_c + TOTAL_W'(rs_q[r]);
    end
  end

  // The reciprocal is exact for every total this block can form.
  assign blurred = prod_q[DIV_SHIFT +: PIXEL_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      rs_tag  <= '0;
      tot_tag <= '0;
      out_tag <= '0;
    end else begin
      rs_tag  <= in_tag;
      tot_tag <= rs_tag;
      out_tag <= tot_tag;
    end
  end

  always_ff @(posedge clk) begin
    rs_q   <= rs_c;
    tot_q  <= tot_c;
    prod_q <= PROD_W'(tot_q) * PROD_W'(DIV_RECIP);
  end

endmodule

// File: hdl/gb5_outq.sv
// ----------------------------------------------------------------------------
// gb5_outq: result queue in front of the output stream.
// Holds finished results while the consumer stalls.
// ----------------------------------------------------------------------------
module gb5_outq import gb5_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  tag_t    in_tag,
  input  sample_t din,
  input  logic    m_ready,
  output logic    m_valid,
  output sample_t m_data,
  output logic    m_last
);

  typedef struct packed {
    sample_t blurred;
    logic    last;
  } entry_t;

  entry_t                fifo [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr;
  logic [OQ_PTR_W-1:0]   rd_ptr;
  logic [OQ_CNT_W-1:0]   count;
  logic                  push;
  logic                  pop;

  assign push    = in_tag.valid;
  assign pop     = m_valid && m_ready;
  assign m_valid = count != '0;
  assign m_data  = fifo[rd_ptr].blurred;
  assign m_last  = fifo[rd_ptr].last;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + OQ_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - OQ_CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{blurred: din, last: in_tag.last};
    end
  end

endmodule

// File: hdl/gaussian_blur_5x5_clamp.sv
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_clamp: 5x5 Gaussian blur (weights over 273), edge clamped.
// Path: a result passes the column, window, row sum, total and product registers.
// Throughput: 1 beat per cycle while the queue has room, one read-modify-write of the line store each.
// Reset: control and registers (1024 x 1024) clear at once; store not cleared.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_clamp import gb5_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [15:0] pixel
  input  logic                  s_axis_tuser,   // [0] kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // [15:0] blurred
  output logic                  m_axis_tlast    // frame_end
);

  logic                accept;
  logic                go;
  item_t               item;
  tag_t                win_tag;
  window_t             window;
  tag_t                res_tag;
  sample_t             res_data;
  logic [OQ_CNT_W-1:0] credit;
  logic                credit_inc;
  logic                credit_dec;

  // Input is taken while the queue has room for every result in flight.
  assign s_axis_tready = credit < OQ_CNT_W'(OQ_DEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign credit_inc    = go && item.emit;
  assign credit_dec    = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else if (credit_inc && !credit_dec) begin
      credit <= credit + OQ_CNT_W'(1);
    end else if (credit_dec && !credit_inc) begin
      credit <= credit - OQ_CNT_W'(1);
    end
  end

  gb5_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .kind      (s_axis_tuser),
    .pixel     (s_axis_tdata),
    .go        (go),
    .item      (item)
  );

  gb5_column u_column (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .item    (item),
    .win_tag (win_tag),
    .window  (window)
  );

  gb5_filter u_filter (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (win_tag),
    .window  (window),
    .out_tag (res_tag),
    .blurred (res_data)
  );

  gb5_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (res_tag),
    .din     (res_data),
    .m_ready (m_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_data  (m_axis_tdata),
    .m_last  (m_axis_tlast)
  );

endmodule
